/* design/efqf_pkg.sv */
// Shared types, constants and the CRC-32 byte update for the Ethernet frame queue framer.
// Used by the framer top level and by its wire output stage; depends on nothing else.
package efqf_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
   localparam logic [7:0] PREAMBLE_VALUE = 8'h55;
   localparam logic [7:0] SFD_VALUE = 8'hD5;

   typedef enum logic [2:0] {
      KIND_IDLE,
      KIND_CONST,
      KIND_DATA,
      KIND_PAD,
      KIND_FCS
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [7:0] value;
      logic [1:0] fcs_index;
   } tick_info_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'h000000, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* design/efqf_wire_out.sv */
// Wire output stage of the Ethernet frame queue framer: running CRC-32 and output register.
// Takes one decoded tick item and the frame byte read from the store; uses efqf_pkg.
module efqf_wire_out
   import efqf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  tick_info_type in_info,
   input  logic [7:0]    rd_data,
   output logic          take,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [15:0]   rsp_tdata   // wire_valid [0], wire_byte [8:1]
);

   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic [31:0] fcs;
   logic        out_valid_ff;
   logic        wire_valid_ff;
   logic [7:0]  wire_byte_ff;
   logic        wire_valid;
   logic [7:0]  wire_byte;

   assign take = in_valid && (!out_valid_ff || rsp_tready);
   assign fcs = ~crc_ff;

   always_comb begin
      crc_in = crc_ff;
      wire_valid = 1'b1;
      wire_byte = in_info.value;
      case (in_info.kind)
         KIND_CONST: begin
            crc_in = CRC_INIT;
         end
         KIND_DATA: begin
            wire_byte = rd_data;
            crc_in = crc_byte(crc_ff, rd_data);
         end
         KIND_PAD: begin
            wire_byte = 8'h00;
            crc_in = crc_byte(crc_ff, 8'h00);
         end
         KIND_FCS: begin
            wire_byte = fcs[{in_info.fcs_index, 3'b000} +: 8];
         end
         default: begin
            wire_valid = 1'b0;
            wire_byte = 8'h00;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            crc_ff <= crc_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         wire_valid_ff <= wire_valid;
         wire_byte_ff <= wire_byte;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {7'b0000000, wire_byte_ff, wire_valid_ff};

endmodule

/* design/ethernet_frame_queue_framer.sv */
// Ethernet frame queue framer: slot ring in a byte memory, tick sequencer and length memory.
// Instantiates efqf_wire_out; uses efqf_pkg.
//
// Usage: each input item on the req_ channel is either a frame byte to store (tuser 0, tlast on
// the final byte of a frame) or a wire byte time tick (tuser 1). Stored frames go into a ring
// of FRAME_SLOTS slots of SLOT_BYTES bytes; the ring holds at most FRAME_SLOTS-1 frames, and a
// frame whose first byte finds it full is dropped whole. Bytes past SLOT_BYTES are discarded.
// Every tick yields one rsp_ item: preamble, SFD, frame bytes, zero pad up to MIN_FRAME_BYTES,
// the FCS least significant byte first, then GAP_BYTES+1 idle ticks, the last of which frees
// the slot. A store yields no item.
// One item is accepted per cycle while req_tready is high. A tick's result passes through the
// read stage register, which holds the synchronous read of the frame memory, and then the output
// register that holds the running CRC-32. When rsp_tready is low the result stays in the output register,
// one more tick waits in the read stage, and req_tready then falls until the output drains.
// After reset the ring is empty and the first tick gives an idle item; the memories need no
// clearing pass, since only written entries are ever read.
module ethernet_frame_queue_framer
   import efqf_pkg::*;
#(
   parameter int FRAME_SLOTS = 32,
   parameter int SLOT_BYTES = 2048,
   parameter int PREAMBLE_BYTES = 7,
   parameter int GAP_BYTES = 12,
   parameter int MIN_FRAME_BYTES = 60
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // frame_byte [7:0]
   input  logic        req_tlast,   // frame_last
   input  logic        req_tuser,   // mode [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // wire_valid [0], wire_byte [8:1]
);

   localparam int SLOT_W = $clog2(FRAME_SLOTS);
   localparam int CNT_W = $clog2(SLOT_BYTES + 1);
   localparam int ADDR_W = $clog2(FRAME_SLOTS * SLOT_BYTES);
   localparam int POS_MAX = PREAMBLE_BYTES + 1 + SLOT_BYTES + 4 + GAP_BYTES;
   localparam int POS_W = $clog2(POS_MAX + 1);
   localparam int LAST_SLOT = FRAME_SLOTS - 1;

   logic [7:0]       frame_mem [FRAME_SLOTS * SLOT_BYTES];
   logic [CNT_W-1:0] slot_len_mem [FRAME_SLOTS];

   logic [SLOT_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in, count_grown;
   logic              dropping_ff, dropping_in;
   logic              active_ff, active_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  len_q_ff;
   logic [7:0]        rd_data_ff;
   logic              s1_valid_ff, s1_valid_in;
   tick_info_type     s1_info_ff, s1_info_in, info_new;

   logic              accept, store_acc, tick_acc, take;
   logic              store_we, len_we, rd_en, drop_now;
   logic [SLOT_W-1:0] tail_next, head_next;
   logic [ADDR_W-1:0] store_addr, data_addr;
   logic [CNT_W-1:0]  padded;
   logic [POS_W-1:0]  cur_pos, data_off, data_end, fcs_start, gap_start, end_pos, fcs_off;

   assign req_tready = !s1_valid_ff || take;
   assign accept = req_tvalid && req_tready;
   assign store_acc = accept && !req_tuser;
   assign tick_acc = accept && req_tuser;

   assign tail_next = (tail_ff == SLOT_W'(LAST_SLOT)) ? '0 : tail_ff + 1'b1;
   assign head_next = (head_ff == SLOT_W'(LAST_SLOT)) ? '0 : head_ff + 1'b1;
   assign drop_now = dropping_ff || (count_ff == '0 && tail_next == head_ff);
   assign store_addr = ADDR_W'(tail_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(count_ff);

   always_comb begin
      dropping_in = dropping_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      count_grown = count_ff;
      store_we = 1'b0;
      len_we = 1'b0;
      if (store_acc) begin
         if (drop_now) begin
            dropping_in = !req_tlast;
         end else begin
            if (count_ff < CNT_W'(SLOT_BYTES)) begin
               store_we = 1'b1;
               count_grown = count_ff + 1'b1;
            end
            if (req_tlast) begin
               len_we = 1'b1;
               tail_in = tail_next;
               count_in = '0;
            end else begin
               count_in = count_grown;
            end
         end
      end
   end

   assign padded = (len_q_ff < CNT_W'(MIN_FRAME_BYTES)) ? CNT_W'(MIN_FRAME_BYTES) : len_q_ff;
   assign cur_pos = active_ff ? pos_ff : '0;
   assign data_off = cur_pos - POS_W'(PREAMBLE_BYTES + 1);
   assign data_end = POS_W'(PREAMBLE_BYTES + 1) + POS_W'(len_q_ff);
   assign fcs_start = POS_W'(PREAMBLE_BYTES + 1) + POS_W'(padded);
   assign gap_start = fcs_start + POS_W'(4);
   assign end_pos = gap_start + POS_W'(GAP_BYTES);
   assign fcs_off = cur_pos - fcs_start;
   assign data_addr = ADDR_W'(head_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(data_off);

   always_comb begin
      active_in = active_ff;
      pos_in = pos_ff;
      head_in = head_ff;
      rd_en = 1'b0;
      info_new = '{kind: KIND_IDLE, value: 8'h00, fcs_index: 2'd0};
      if (tick_acc && (active_ff || head_ff != tail_ff)) begin
         active_in = 1'b1;
         pos_in = cur_pos + 1'b1;
         if (cur_pos < POS_W'(PREAMBLE_BYTES)) begin
            info_new.kind = KIND_CONST;
            info_new.value = PREAMBLE_VALUE;
         end else if (cur_pos == POS_W'(PREAMBLE_BYTES)) begin
            info_new.kind = KIND_CONST;
            info_new.value = SFD_VALUE;
         end else if (cur_pos < data_end) begin
            info_new.kind = KIND_DATA;
            rd_en = 1'b1;
         end else if (cur_pos < fcs_start) begin
            info_new.kind = KIND_PAD;
         end else if (cur_pos < gap_start) begin
            info_new.kind = KIND_FCS;
            info_new.fcs_index = fcs_off[1:0];
         end else if (cur_pos == end_pos) begin
            active_in = 1'b0;
            pos_in = '0;
            head_in = head_next;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_info_in = s1_info_ff;
      if (tick_acc) begin
         s1_valid_in = 1'b1;
         s1_info_in = info_new;
      end else if (take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         dropping_ff <= 1'b0;
         active_ff <= 1'b0;
         pos_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         dropping_ff <= dropping_in;
         active_ff <= active_in;
         pos_ff <= pos_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_info_ff <= s1_info_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         frame_mem[store_addr] <= req_tdata;
      end
      if (rd_en) begin
         rd_data_ff <= frame_mem[data_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         slot_len_mem[tail_ff] <= count_grown;
      end
      len_q_ff <= slot_len_mem[head_ff];
   end

   efqf_wire_out u_wire_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid_ff),
      .in_info    (s1_info_ff),
      .rd_data    (rd_data_ff),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_active_has_frame: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> head_ff != tail_ff)
      else $error("Emitter active on an empty ring.");

   a_idle_pos_zero: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> pos_ff == '0)
      else $error("Tick position not cleared while the emitter is idle.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOT_BYTES))
      else $error("Store count exceeds the slot size.");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !take |=> s1_valid_ff && $stable(s1_info_ff)
         && (s1_info_ff.kind != KIND_DATA || $stable(rd_data_ff)))
      else $error("Read stage item changed while stalled.");

   a_no_drop_write: assert property (@(posedge clock) disable iff (reset)
      store_acc && drop_now |-> !store_we && !len_we)
      else $error("Dropped frame byte reached the slot memory.");

endmodule

/* dv/ethernet_frame_queue_framer_tb.sv */
// Self-checking testbench for the Ethernet frame queue framer: directed table, then random
// frames, ticks and noise, with every wire item compared against the table or a shadow of the slot ring.
// Depends on efqf_pkg and the ethernet_frame_queue_framer top level.
`timescale 1ns / 1ps

module ethernet_frame_queue_framer_tb
   import efqf_pkg::*;
();

   localparam int SLOTS = 32;
   localparam int SLOT_BYTES = 2048;
   localparam int PREAMBLE_BYTES = 7;
   localparam int GAP_BYTES = 12;
   localparam int MIN_FRAME_BYTES = 60;
   localparam int RANDOM_ITEMS = 1800;

   localparam bit MODE_STORE = 1'b0;
   localparam bit MODE_TICK = 1'b1;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } wire_item_type;

   typedef struct packed {
      bit         mode;
      logic [7:0] data;
      bit         last;
      bit         typed;
      bit         exp_valid;
      logic [7:0] exp_data;
   } stim_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   ethernet_frame_queue_framer #(
      .FRAME_SLOTS(SLOTS),
      .SLOT_BYTES(SLOT_BYTES),
      .PREAMBLE_BYTES(PREAMBLE_BYTES),
      .GAP_BYTES(GAP_BYTES),
      .MIN_FRAME_BYTES(MIN_FRAME_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // Shadow copy of the slot ring and the emitter.
   logic [7:0]  frame_mem [0:SLOTS*SLOT_BYTES-1];
   int          slot_len [0:SLOTS-1];
   int          head;
   int          tail;
   int          fill_count;
   bit          dropping;
   bit          emitting;
   int          emit_pos;
   logic [31:0] crc;

   wire_item_type wire_due [$];
   int          items_sent;
   int          wire_checked;
   int          fail_count;
   int          frames_stored;
   int          frames_sent;
   int          frames_dropped;
   int          bytes_truncated;
   bit          no_gaps;

   stim_row_type directed_rows [19] = '{
      '{MODE_TICK,  8'h00, 1'b0, 1'b1, 1'b0, 8'h00},
      '{MODE_STORE, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00},
      '{MODE_STORE, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
      '{MODE_STORE, 8'h80, 1'b1, 1'b0, 1'b0, 8'h00},
      '{MODE_TICK,  8'h00, 1'b0, 1'b1, 1'b1, PREAMBLE_VALUE},
      '{MODE_TICK,  8'hFF, 1'b1, 1'b1, 1'b1, PREAMBLE_VALUE},
      '{MODE_TICK,  8'h00, 1'b0, 1'b1, 1'b1, PREAMBLE_VALUE},
      '{MODE_TICK,  8'h00, 1'b0, 1'b1, 1'b1, PREAMBLE_VALUE},
      '{MODE_TICK,  8'h00, 1'b0, 1'b1, 1'b1, PREAMBLE_VALUE},
      '{MODE_TICK,  8'h00, 1'b0, 1'b1, 1'b1, PREAMBLE_VALUE},
      '{MODE_TICK,  8'h00, 1'b0, 1'b1, 1'b1, PREAMBLE_VALUE},
      '{MODE_TICK,  8'h00, 1'b0, 1'b1, 1'b1, SFD_VALUE},
      '{MODE_TICK,  8'h00, 1'b0, 1'b1, 1'b1, 8'hFF},
      '{MODE_TICK,  8'h00, 1'b0, 1'b1, 1'b1, 8'h00},
      '{MODE_STORE, 8'h7F, 1'b0, 1'b0, 1'b0, 8'h00},
      '{MODE_TICK,  8'h00, 1'b0, 1'b1, 1'b1, 8'h00},
      '{MODE_STORE, 8'h01, 1'b1, 1'b0, 1'b0, 8'h00},
      '{MODE_TICK,  8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
      '{MODE_TICK,  8'h00, 1'b0, 1'b0, 1'b0, 8'h00}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] d);
      logic [31:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
         if (r[0] ^ d[i]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom_range(MIN_FRAME_BYTES - 2, MIN_FRAME_BYTES + 2);
      if (r < 70) return $urandom_range(1, 64);
      if (r < 95) return $urandom_range(60, 200);
      return $urandom_range(1, 4);
   endfunction

   task automatic framer_step(input bit mode, input logic [7:0] data, input bit last,
                              output bit has_result, output wire_item_type w);
      int len;
      int padded;
      int p;
      logic [7:0] d;
      logic [31:0] fcs;
      has_result = 1'b0;
      w = '{1'b0, 8'h00};
      if (mode == MODE_STORE) begin
         if (!dropping && fill_count == 0 && (tail + 1) % SLOTS == head) begin
            dropping = 1'b1;
            frames_dropped++;
         end
         if (dropping) begin
            if (last) dropping = 1'b0;
            return;
         end
         if (fill_count < SLOT_BYTES) begin
            frame_mem[tail*SLOT_BYTES + fill_count] = data;
            fill_count++;
         end else begin
            bytes_truncated++;
         end
         if (last) begin
            slot_len[tail] = fill_count;
            tail = (tail + 1) % SLOTS;
            fill_count = 0;
            frames_stored++;
         end
         return;
      end
      has_result = 1'b1;
      if (!emitting) begin
         if (head == tail) return;
         emitting = 1'b1;
         emit_pos = 0;
         crc = CRC_INIT;
      end
      len = slot_len[head];
      padded = (len < MIN_FRAME_BYTES) ? MIN_FRAME_BYTES : len;
      p = emit_pos;
      emit_pos++;
      if (p < PREAMBLE_BYTES) begin
         w = '{1'b1, PREAMBLE_VALUE};
      end else if (p == PREAMBLE_BYTES) begin
         w = '{1'b1, SFD_VALUE};
      end else if (p < PREAMBLE_BYTES + 1 + padded) begin
         p = p - PREAMBLE_BYTES - 1;
         d = (p < len) ? frame_mem[head*SLOT_BYTES + p] : 8'h00;
         crc = crc_next(crc, d);
         w = '{1'b1, d};
      end else if (p < PREAMBLE_BYTES + 1 + padded + 4) begin
         p = p - PREAMBLE_BYTES - 1 - padded;
         fcs = ~crc;
         w = '{1'b1, fcs[8*p +: 8]};
      end else if (p >= PREAMBLE_BYTES + 1 + padded + 4 + GAP_BYTES) begin
         head = (head + 1) % SLOTS;
         emitting = 1'b0;
         emit_pos = 0;
         frames_sent++;
      end
   endtask

   task automatic offer_item(input bit mode, input logic [7:0] data, input bit last,
                             input bit typed, input bit exp_valid, input logic [7:0] exp_data);
      int gap;
      bit has_result;
      wire_item_type w;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= data;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      framer_step(mode, data, last, has_result, w);
      if (has_result) begin
         if (typed) begin
            w.valid = exp_valid;
            w.data = exp_data;
         end
         wire_due.push_back(w);
      end
      items_sent++;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) begin
         offer_item(MODE_TICK, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, 1'b0, 8'h00);
      end
   endtask

   task automatic send_frame(input int len, input int tick_pct);
      for (int i = 0; i < len; i++) begin
         while ($urandom_range(0, 99) < tick_pct) send_ticks(1);
         offer_item(MODE_STORE, 8'($urandom), i == len - 1, 1'b0, 1'b0, 8'h00);
      end
   endtask

   task automatic send_noise(input int count);
      repeat (count) begin
         offer_item(1'($urandom_range(0, 1)), 8'($urandom), $urandom_range(0, 3) == 0,
                    1'b0, 1'b0, 8'h00);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (wire_due.size() == 0) begin
            $error("unexpected wire item: rsp_tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            wire_item_type exp_item;
            exp_item = wire_due.pop_front();
            if (rsp_tdata[0] !== exp_item.valid) begin
               $error("wire_valid: expected %0d, actual %0d", exp_item.valid, rsp_tdata[0]);
               fail_count++;
            end
            if (rsp_tdata[8:1] !== exp_item.data) begin
               $error("wire_byte: expected %h, actual %h", exp_item.data, rsp_tdata[8:1]);
               fail_count++;
            end
            wire_checked++;
         end
      end
   end

   // Two long hold-offs of rsp_tready stall the output, and so the input, while the sender keeps offering items.
   initial begin : receiver
      int holds_done;
      holds_done = 0;
      wait (!reset);
      forever begin
         if ((holds_done == 0 && wire_checked >= 300) ||
             (holds_done == 1 && wire_checked >= 600)) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if ($urandom_range(0, 9) < 7) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int random_start;
      int pick;
      int wait_cycles;
      bit burst_done;
      head = 0;
      tail = 0;
      fill_count = 0;
      dropping = 1'b0;
      emitting = 1'b0;
      emit_pos = 0;
      crc = CRC_INIT;
      items_sent = 0;
      wire_checked = 0;
      fail_count = 0;
      frames_stored = 0;
      frames_sent = 0;
      frames_dropped = 0;
      bytes_truncated = 0;
      no_gaps = 1'b0;
      burst_done = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         offer_item(directed_rows[i].mode, directed_rows[i].data, directed_rows[i].last,
                    directed_rows[i].typed, directed_rows[i].exp_valid,
                    directed_rows[i].exp_data);
      end

      random_start = items_sent;
      while (items_sent < random_start + RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(0, 9) == 0);
         if (!burst_done && items_sent > random_start + 1400) begin
            // Enough short frames back to back to fill the ring and drop the rest.
            burst_done = 1'b1;
            no_gaps = 1'b1;
            repeat (SLOTS + 2) send_frame($urandom_range(1, 3), 0);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               send_frame(pick_length(), $urandom_range(0, 60));
            end else if (pick < 85) begin
               send_ticks($urandom_range(10, 150));
            end else begin
               send_noise($urandom_range(1, 20));
            end
         end
      end

      no_gaps = 1'b0;
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (wire_due.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (wire_due.size() != 0) begin
         $error("%0d expected wire items never arrived", wire_due.size());
         fail_count++;
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d items: %0d frames stored, %0d framed on the wire, %0d dropped on a full ring.",
               items_sent, frames_stored, frames_sent, frames_dropped);
      $display("Checked %0d wire items; %0d oversize bytes discarded; %0d mismatches.",
               wire_checked, bytes_truncated, fail_count);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
